FILE: rtl/text_to_tile_glyph_stream_core_assert.svh
// ----------------------------------------------------------------------------
// text_to_tile_glyph_stream_core_assert.svh
// assertion macros used by the glyph stream rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_TILE_GLYPH_STREAM_CORE_ASSERT_SVH
`define TEXT_TO_TILE_GLYPH_STREAM_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgs assertion failed");

// next-cycle implication, disabled while in reset
`define TGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgs assertion failed");

`endif

FILE: rtl/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg
// types, constants and helper functions of the text to tile glyph stream
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int unsigned POS_WIDTH = 16;
  localparam int unsigned MAX_TILES = 3;

  typedef logic [POS_WIDTH-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // match stage codes
  localparam logic [1:0] STG_IDLE  = 2'd0;
  localparam logic [1:0] STG_TILDE = 2'd1;
  localparam logic [1:0] STG_TC    = 2'd2;
  localparam logic [1:0] STG_SEL   = 2'd3;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UC     = 8'h43;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // glyph sheet rows
  localparam logic [2:0] GROW_UPPER = 3'd1;
  localparam logic [2:0] GROW_LOWER = 3'd2;
  localparam logic [2:0] GROW_DIGIT = 3'd3;
  localparam logic [2:0] GROW_PUNCT = 3'd4;
  localparam logic [2:0] GROW_BRACK = 3'd5;
  localparam logic [2:0] GROW_BRACE = 3'd6;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_end;
  } in_word_t;

  typedef struct packed {
    logic [4:0] glyph_col;
    logic [2:0] glyph_row;
    pos_t       text_col;
    pos_t       text_row;
    logic [3:0] color_code;
    logic       run_end;
  } out_word_t;

  typedef struct packed {
    logic [4:0] gcol;
    logic [2:0] grow;
  } glyph_t;

  typedef struct packed {
    logic [1:0] stage;
    logic [3:0] color;
    pos_t       col;
    pos_t       row;
  } state_t;

  // up to three tiles produced by one input word
  typedef struct packed {
    logic [1:0]                cnt;
    glyph_t [MAX_TILES-1:0]    glyph;
    pos_t   [MAX_TILES-1:0]    col;
    pos_t                      row;
    logic [3:0]                color;
  } burst_t;

  function automatic glyph_t glyph_of(logic [7:0] code);
    logic [7:0] c;
    logic [7:0] d;
    glyph_t     g;
    c = (code == CH_NL) ? CH_SPACE : code;
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
      g.grow = GROW_UPPER;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA;
      g.grow = GROW_LOWER;
    end else if (c >= CH_SPACE && c <= CH_NINE) begin
      d = c - CH_SPACE;
      g.grow = GROW_DIGIT;
    end else if (c >= CH_COLON && c <= CH_AT) begin
      d = c - CH_COLON;
      g.grow = GROW_PUNCT;
    end else if (c >= CH_LBRK && c <= CH_BTICK) begin
      d = c - CH_LBRK;
      g.grow = GROW_BRACK;
    end else if (c >= CH_LBRACE && c <= CH_TILDE) begin
      d = c - CH_LBRACE;
      g.grow = GROW_BRACE;
    end else begin
      d = CH_QMARK - CH_COLON;
      g.grow = GROW_PUNCT;
    end
    g.gcol = d[4:0];
    return g;
  endfunction

  // saturating position increment by 0..3
  function automatic pos_t sat_inc(pos_t p, logic [1:0] inc);
    logic [POS_WIDTH:0] s;
    s = {1'b0, p} + {{(POS_WIDTH-1){1'b0}}, inc};
    return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/tgs_dec.sv
// ----------------------------------------------------------------------------
// tgs_dec
// per-word decode: escape matching, tile list and next position and color
// ----------------------------------------------------------------------------
module tgs_dec import tgs_pkg::*; (
  input  state_t     state_i,
  input  logic [3:0] pal_cnt_i,
  input  in_word_t   word_i,
  output burst_t     burst_o,
  output state_t     state_o
);

  logic [7:0] c;
  logic       fail;
  logic [1:0] stg;
  logic [3:0] clr;
  logic [1:0] n;
  logic       emit_nl;
  logic [7:0] dig;
  logic [7:0] ch [MAX_TILES];

  assign c   = word_i.char_code;
  assign dig = c - CH_ZERO;

  always_comb begin
    for (int i = 0; i < MAX_TILES; i++) begin
      ch[i] = CH_SPACE;
    end
    n       = 2'd0;
    stg     = state_i.stage;
    clr     = state_i.color;
    emit_nl = 1'b0;
    fail    = (state_i.stage == STG_TILDE && c != CH_UC) ||
              (state_i.stage == STG_TC && c != CH_LBRK);

    // failed match: release held bytes first
    if (fail) begin
      ch[n] = CH_TILDE;
      n     = n + 2'd1;
      if (state_i.stage == STG_TC) begin
        ch[n] = CH_UC;
        n     = n + 2'd1;
      end
      stg = STG_IDLE;
    end

    case (state_i.stage)
      STG_TILDE: if (!fail) stg = STG_TC;
      STG_TC:    if (!fail) stg = STG_SEL;
      STG_SEL: begin
        // selector byte, non-digits and out of range digits are dropped
        if (c >= CH_ZERO && c <= CH_NINE && dig[3:0] < pal_cnt_i) begin
          clr = dig[3:0] + 4'd1;
        end
        stg = STG_IDLE;
      end
      default: ;
    endcase

    if (state_i.stage == STG_IDLE || fail) begin
      if (c == CH_TILDE) begin
        stg = STG_TILDE;
      end else begin
        ch[n]   = c;
        n       = n + 2'd1;
        emit_nl = (c == CH_NL);
      end
    end

    // end of string flushes a held ~ or ~C
    if (word_i.string_end) begin
      if (stg == STG_TILDE || stg == STG_TC) begin
        ch[n] = CH_TILDE;
        n     = n + 2'd1;
      end
      if (stg == STG_TC) begin
        ch[n] = CH_UC;
        n     = n + 2'd1;
      end
    end
  end

  always_comb begin
    burst_o.cnt   = n;
    burst_o.row   = state_i.row;
    burst_o.color = state_i.color;
    for (int i = 0; i < MAX_TILES; i++) begin
      burst_o.glyph[i] = glyph_of(ch[i]);
      burst_o.col[i]   = sat_inc(state_i.col, 2'(i));
    end

    if (word_i.string_end) begin
      state_o.stage = STG_IDLE;
      state_o.color = 4'd0;
      state_o.col   = '0;
      state_o.row   = '0;
    end else begin
      state_o.stage = stg;
      state_o.color = clr;
      // a newline is always the last tile of a word
      if (emit_nl) begin
        state_o.col = '0;
        state_o.row = sat_inc(state_i.row, 2'd1);
      end else begin
        state_o.col = sat_inc(state_i.col, n);
        state_o.row = state_i.row;
      end
    end
  end

endmodule

FILE: rtl/tgs_obuf.sv
// ----------------------------------------------------------------------------
// tgs_obuf
// result register holding one tile burst, drained one word per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module tgs_obuf import tgs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  burst_t    burst_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

`include "text_to_tile_glyph_stream_core_assert.svh"

  logic [1:0] left_q, left_d;
  logic [1:0] idx_q, idx_d;
  burst_t     burst_q;
  logic       take;

  assign out_valid_o = (left_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign ready_o     = (left_q == 2'd0) || (left_q == 2'd1 && take);

  always_comb begin
    left_d = left_q;
    idx_d  = idx_q;
    if (take) begin
      left_d = left_q - 2'd1;
      idx_d  = idx_q + 2'd1;
    end
    if (push_i) begin
      left_d = burst_i.cnt;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
      idx_q  <= 2'd0;
    end else begin
      left_q <= left_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      burst_q <= burst_i;
    end
  end

  always_comb begin
    out_word_o.glyph_col  = burst_q.glyph[idx_q].gcol;
    out_word_o.glyph_row  = burst_q.glyph[idx_q].grow;
    out_word_o.text_col   = burst_q.col[idx_q];
    out_word_o.text_row   = burst_q.row;
    out_word_o.color_code = burst_q.color;
    out_word_o.run_end    = (left_q == 2'd1);
  end

  // a new burst never overwrites undelivered tiles
  `TGS_ASSERT_NOW(a_push_drained, clk_i, rst_ni, push_i, ready_o)
  // index and remaining count never run past the burst
  `TGS_ASSERT_NOW(a_idx_bound, clk_i, rst_ni, out_valid_o,
                  ({1'b0, idx_q} + {1'b0, left_q}) <= 3'(MAX_TILES))
  // mid-burst handoff steps to the next tile
  `TGS_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, take && left_q != 2'd1 && !push_i,
                   idx_q == $past(idx_q) + 2'd1)
  // last tile taken with nothing pushed leaves the output empty
  `TGS_ASSERT_NEXT(a_drain_empty, clk_i, rst_ni, take && left_q == 2'd1 && !push_i,
                   !out_valid_o)

endmodule

FILE: rtl/text_to_tile_glyph_stream_core.sv
// the first tile word of a byte is offered in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one tile word and the output does not stall
// a byte that yields k tile words (k up to 3) holds the input until its last word is taken,
// set by the single result register draining one word per cycle while not stalled
// reset: async active low, clears match stage, color, position and palette count
// ----------------------------------------------------------------------------
// text_to_tile_glyph_stream_core
// turns a text byte stream into tile records with glyph, position and color
// ----------------------------------------------------------------------------
module text_to_tile_glyph_stream_core import tgs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // palette count register
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  // text byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  // tile channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  // text state: match stage, active color, cursor position
  state_t     state_q;
  state_t     state_d;
  logic [3:0] pal_cnt_q;

  burst_t     burst;
  logic       ready;
  logic       accept;
  logic       push;

  // the result register frees up in the same cycle its last word leaves,
  // so a steady one-tile stream never bubbles
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;
  // bytes that only advance the escape match produce no tiles
  assign push       = accept && (burst.cnt != 2'd0);

  // escape matching, glyph lookup and position update for one byte
  tgs_dec u_dec (
    .state_i   (state_q),
    .pal_cnt_i (pal_cnt_q),
    .word_i    (in_word_i),
    .burst_o   (burst),
    .state_o   (state_d)
  );

  // result register and tile serializer
  tgs_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .burst_i     (burst),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // text state advances only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // palette count; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_cnt_q <= 4'd0;
    end else if (cfg_we_i) begin
      pal_cnt_q <= cfg_data_i;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for text_to_tile_glyph_stream_core: a queue-fed driver
// offers text words, a predictor builds the tile words each accepted word
// should yield, and a monitor checks every tile word against them in order
// ----------------------------------------------------------------------------
module tb_top import tgs_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned SEG_CYCLES  = 64;

  // clock, reset and block ports; the driven inputs are all known from time zero
  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      cfg_we_i   = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i  = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  text_to_tile_glyph_stream_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // text words waiting to be offered, tile words waiting to arrive
  in_word_t  text_queue[$];
  out_word_t tiles_due[$];
  out_word_t tile_burst[$];
  int unsigned fed = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  // predictor state, mirrors the block's own registers
  logic [1:0] stage     = STG_IDLE;
  logic [3:0] cur_color = '0;
  pos_t       col_pos   = '0;
  pos_t       row_pos   = '0;
  logic [3:0] pal_count = '0;

  // stimulus shaping flags, written by the initial block at falling edges
  bit burst_mode = 1'b0;
  bit hold_arm   = 1'b0;

  // driver and receiver private counters
  bit          took;
  int unsigned gap_left  = 0;
  int unsigned drv_seg   = 0;
  bit          drv_quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_seg  = 0;
  bit          stall_quiet = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  out_word_t   due_tile;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tile sheet position of a byte, newline drawn as space
  function automatic glyph_t sheet_glyph(input logic [7:0] code);
    logic [7:0] c;
    logic [7:0] base;
    logic [7:0] off;
    glyph_t     g;
    c = (code == CH_NL) ? CH_SPACE : code;
    if (c >= CH_UA && c <= CH_UZ) begin
      base = CH_UA;
      g.grow = GROW_UPPER;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      base = CH_LA;
      g.grow = GROW_LOWER;
    end else if (c >= CH_SPACE && c <= CH_NINE) begin
      base = CH_SPACE;
      g.grow = GROW_DIGIT;
    end else if (c >= CH_COLON && c <= CH_AT) begin
      base = CH_COLON;
      g.grow = GROW_PUNCT;
    end else if (c >= CH_LBRK && c <= CH_BTICK) begin
      base = CH_LBRK;
      g.grow = GROW_BRACK;
    end else if (c >= CH_LBRACE && c <= CH_TILDE) begin
      base = CH_LBRACE;
      g.grow = GROW_BRACE;
    end else begin
      // unmapped bytes show a question mark
      c = CH_QMARK;
      base = CH_COLON;
      g.grow = GROW_PUNCT;
    end
    off = c - base;
    g.gcol = off[4:0];
    return g;
  endfunction

  // one tile at the current position, then advance with saturation
  function automatic void emit_tile(input logic [7:0] c);
    out_word_t t;
    glyph_t    g;
    if (tile_burst.size() >= MAX_TILES) return;
    g = sheet_glyph(c);
    t.glyph_col  = g.gcol;
    t.glyph_row  = g.grow;
    t.text_col   = col_pos;
    t.text_row   = row_pos;
    t.color_code = cur_color;
    t.run_end    = 1'b0;
    tile_burst.insert(tile_burst.size(), t);
    if (c == CH_NL) begin
      col_pos = '0;
      if (row_pos != POS_MAX) row_pos = row_pos + 1'b1;
    end else if (col_pos != POS_MAX) begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // a held ~ or ~C goes out as plain tiles
  function automatic void flush_held_tiles();
    if (stage == STG_TILDE || stage == STG_TC) emit_tile(CH_TILDE);
    if (stage == STG_TC) emit_tile(CH_UC);
    if (stage != STG_SEL) stage = STG_IDLE;
  endfunction

  function automatic void take_fresh(input logic [7:0] c);
    if (c == CH_TILDE) stage = STG_TILDE;
    else emit_tile(c);
  endfunction

  // tile words caused by one accepted text word
  function automatic void predict_tiles(input in_word_t w);
    logic [7:0]  c;
    logic [7:0]  sel;
    int unsigned n;
    out_word_t   t;
    c = w.char_code;
    case (stage)
      STG_IDLE: begin
        take_fresh(c);
      end
      STG_TILDE: begin
        if (c == CH_UC) stage = STG_TC;
        else begin
          flush_held_tiles();
          take_fresh(c);
        end
      end
      STG_TC: begin
        if (c == CH_LBRK) stage = STG_SEL;
        else begin
          flush_held_tiles();
          take_fresh(c);
        end
      end
      default: begin
        // selector: digits below the palette count pick a color, others are dropped
        sel = c - CH_ZERO;
        if (c >= CH_ZERO && c <= CH_NINE && sel < {4'b0, pal_count})
          cur_color = sel[3:0] + 4'd1;
        stage = STG_IDLE;
      end
    endcase
    if (w.string_end) begin
      flush_held_tiles();
      stage = STG_IDLE;
      cur_color = '0;
      col_pos = '0;
      row_pos = '0;
    end
    // last tile of the run carries run_end
    n = tile_burst.size();
    for (int unsigned i = 0; i < n; i++) begin
      t = tile_burst.pop_front();
      t.run_end = (i == n - 1);
      tiles_due.insert(tiles_due.size(), t);
    end
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // driver: offers queued words, holds a stalled word steady
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) predict_tiles(in_word_i);
      // quiet segments give stretches with no idling
      if (drv_seg == 0) begin
        drv_seg = SEG_CYCLES;
        drv_quiet = ($urandom_range(0, 3) == 0);
      end
      drv_seg--;
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (text_queue.size() != 0) begin
          in_word_i <= text_queue.pop_front();
          in_valid_i <= 1'b1;
          gap_left = (burst_mode || drv_quiet) ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random gaps, plus one long hold so the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (burst_mode) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_seg == 0) begin
        stall_seg = SEG_CYCLES;
        stall_quiet = ($urandom_range(0, 3) == 0);
      end
      stall_seg--;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!stall_quiet) stall_left = pick_gap();
      end
    end
  end

  // monitor: every accepted tile word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tiles_due.size() == 0) begin
        $display("%0t: unexpected tile word, expected none, actual %h", $time, out_word_o);
        errors++;
      end else begin
        due_tile = tiles_due.pop_front();
        check_field("glyph_col", due_tile.glyph_col, out_word_o.glyph_col);
        check_field("glyph_row", due_tile.glyph_row, out_word_o.glyph_row);
        check_field("text_col", due_tile.text_col, out_word_o.text_col);
        check_field("text_row", due_tile.text_row, out_word_o.text_row);
        check_field("color_code", due_tile.color_code, out_word_o.color_code);
        check_field("run_end", due_tile.run_end, out_word_o.run_end);
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_text(input logic [7:0] c, input logic e);
    in_word_t w;
    w.char_code = c;
    w.string_end = e;
    text_queue.insert(text_queue.size(), w);
    fed++;
  endtask

  // mostly printable text, with newlines, tildes and any byte mixed in
  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_NL;
    if (r < 22) return 8'($urandom_range(0, 255));
    if (r < 27) return CH_TILDE;
    if (r < 31) return CH_UC;
    return 8'($urandom_range(CH_SPACE, CH_LBRACE + 2));
  endfunction

  // everything offered, every tile back, then the block's own latency
  task automatic wait_idle();
    @(negedge clk_i);
    while (text_queue.size() != 0 || in_valid_i || tiles_due.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // palette count write, only called while the block is idle
  task automatic set_palette(input logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pal_count = v;
    @(negedge clk_i);
  endtask

  // random strings: mostly color sequences and text runs, some broken sequences
  task automatic random_text(input int unsigned count);
    int unsigned goal;
    int unsigned kind;
    int unsigned len;
    int unsigned m;
    logic [7:0]  sel;
    goal = fed + count;
    while (fed < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        sel = ($urandom_range(0, 3) == 0) ? text_byte() :
              8'(CH_ZERO + $urandom_range(0, 9));
        queue_text(CH_TILDE, 1'b0);
        queue_text(CH_UC, 1'b0);
        queue_text(CH_LBRK, $urandom_range(0, 19) == 0);
        queue_text(sel, $urandom_range(0, 9) == 0);
      end else if (kind < 44) begin
        m = $urandom_range(0, 2);
        queue_text(CH_TILDE, 1'b0);
        if (m == 0) begin
          queue_text(text_byte(), $urandom_range(0, 4) == 0);
        end else if (m == 1) begin
          queue_text(CH_UC, 1'b0);
          queue_text(text_byte(), $urandom_range(0, 4) == 0);
        end else begin
          queue_text(CH_UC, 1'b1);
        end
      end else if (kind < 93) begin
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
          queue_text(text_byte(), (i == len - 1) && ($urandom_range(0, 5) == 0));
      end else begin
        queue_text(text_byte(), 1'b1);
      end
    end
  endtask

  initial begin
    // reset once, held low from time zero and then released
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: range edges, byte extremes, color select with full palette
    set_palette(4'd10);
    queue_text(CH_UA, 1'b0);
    queue_text(CH_UZ, 1'b0);
    queue_text(CH_LA, 1'b0);
    queue_text(CH_LZ, 1'b0);
    queue_text(CH_SPACE, 1'b0);
    queue_text(CH_NINE, 1'b0);
    queue_text(CH_COLON, 1'b0);
    queue_text(CH_AT, 1'b0);
    queue_text(CH_LBRK, 1'b0);
    queue_text(CH_BTICK, 1'b0);
    queue_text(CH_LBRACE, 1'b0);
    queue_text(8'h00, 1'b0);
    queue_text(8'hFF, 1'b0);
    queue_text(CH_NL, 1'b0);
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b0);
    queue_text(CH_LBRK, 1'b0);
    queue_text(CH_NINE, 1'b0);
    // failed match on a second tilde, then on ~C followed by a letter
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b0);
    queue_text(CH_LA, 1'b0);
    // non-digit selector, then a held ~C flushed by the string end
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b0);
    queue_text(CH_LBRK, 1'b0);
    queue_text(CH_UA, 1'b0);
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b1);
    wait_idle();

    // empty palette: digit out of range, string ending right after ~C[
    set_palette(4'd0);
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b0);
    queue_text(CH_LBRK, 1'b0);
    queue_text(CH_ZERO, 1'b0);
    queue_text(CH_TILDE, 1'b0);
    queue_text(CH_UC, 1'b0);
    queue_text(CH_LBRK, 1'b1);
    queue_text(CH_LZ, 1'b1);
    wait_idle();

    // random text under several palette sizes, one long receiver hold
    set_palette(4'($urandom_range(1, 9)));
    hold_arm = 1'b1;
    random_text(70);
    wait_idle();
    set_palette(4'd10);
    random_text(70);
    wait_idle();
    set_palette(4'd0);
    random_text(70);
    wait_idle();

    // full rate run, no idling on either side
    set_palette(4'd10);
    burst_mode = 1'b1;
    random_text(24);
    wait_idle();
    burst_mode = 1'b0;

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: text_to_tile_glyph_stream_core.f
+incdir+rtl
rtl/tgs_pkg.sv
rtl/tgs_dec.sv
rtl/tgs_obuf.sv
rtl/text_to_tile_glyph_stream_core.sv
tb/sv/tb_top.sv
